// ----- hw/rtl/rhc_pkg.sv -----
// shared types, constants and the divider step for the rgb to hsv converter
package rhc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 16;
  localparam int unsigned SatW    = 17;
  // quotient bits produced by the divider chain, one per cell
  localparam int unsigned QuoW    = 17;
  // dividend width: sat dividend is delta shifted up by 16
  localparam int unsigned NumW    = 24;
  localparam int unsigned NumHiW  = NumW - QuoW;

  localparam logic [HueW-1:0] HueSixty = 16'd7680;
  localparam logic [HueW-1:0] HueFull  = 16'd46080;
  localparam logic [HueW-1:0] HueRed   = 16'd0;
  localparam logic [HueW-1:0] HueGreen = 16'd15360;
  localparam logic [HueW-1:0] HueBlue  = 16'd30720;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha_in;
  } pix_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] alpha_out;
  } hsv_t;

  // one restoring division in flight
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuoW-1:0]  num;
    logic [QuoW-1:0]  quo;
    logic [ChanW-1:0] div;
  } lane_t;

  // pixel data that rides along with the quotients
  typedef struct packed {
    logic             gray;
    logic             neg;
    logic [HueW-1:0]  offset;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] alpha;
  } side_t;

  typedef struct packed {
    logic  valid;
    side_t side;
    lane_t hue;
    lane_t sat;
  } stage_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic lane_t div_step(lane_t l);
    logic [ChanW:0] trial;
    logic [ChanW:0] diff;
    logic           fits;
    lane_t          r;
    trial = {l.rem, l.num[QuoW-1]};
    diff  = trial - {1'b0, l.div};
    fits  = (trial >= {1'b0, l.div});
    r     = l;
    r.rem = fits ? diff[ChanW-1:0] : trial[ChanW-1:0];
    r.num = {l.num[QuoW-2:0], 1'b0};
    r.quo = {l.quo[QuoW-2:0], fits};
    return r;
  endfunction

endpackage

// ----- hw/rtl/rhc_front.sv -----
// front stage: max, min, delta, sector and dividends for the divider chain
module rhc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rhc_pkg::pix_t pix_i,
  output rhc_pkg::stage_t stage_o
);
  import rhc_pkg::*;

  logic [ChanW-1:0] mx, mn, delta, p, n, mag;
  logic [HueW-1:0]  offset;
  logic             neg;
  logic [NumW-1:0]  hue_num, sat_num;
  logic             valid_q;
  side_t            side_d, side_q;
  lane_t            hue_d, hue_q, sat_d, sat_q;

  always_comb begin
    mx = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    mx = (mx > pix_i.blue) ? mx : pix_i.blue;
    mn = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    mn = (mn < pix_i.blue) ? mn : pix_i.blue;
    delta = mx - mn;

    priority if (mx == pix_i.red) begin
      offset = HueRed;
      p = pix_i.green;
      n = pix_i.blue;
    end else if (mx == pix_i.green) begin
      offset = HueGreen;
      p = pix_i.blue;
      n = pix_i.red;
    end else begin
      offset = HueBlue;
      p = pix_i.red;
      n = pix_i.green;
    end
    neg = (p < n);
    mag = neg ? (n - p) : (p - n);

    // 7680 * mag as two shifts
    hue_num = ({{(NumW-ChanW){1'b0}}, mag} << 13) - ({{(NumW-ChanW){1'b0}}, mag} << 9);
    sat_num = {delta, 16'd0};

    hue_d.rem = {{(ChanW-NumHiW){1'b0}}, hue_num[NumW-1:QuoW]};
    hue_d.num = hue_num[QuoW-1:0];
    hue_d.quo = '0;
    hue_d.div = delta;
    sat_d.rem = {{(ChanW-NumHiW){1'b0}}, sat_num[NumW-1:QuoW]};
    sat_d.num = sat_num[QuoW-1:0];
    sat_d.quo = '0;
    sat_d.div = mx;

    side_d.gray   = (delta == '0);
    side_d.neg    = neg;
    side_d.offset = offset;
    side_d.value  = mx;
    side_d.alpha  = pix_i.alpha_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    hue_q  <= hue_d;
    sat_q  <= sat_d;
  end

  assign stage_o = '{valid: valid_q, side: side_q, hue: hue_q, sat: sat_q};

endmodule

// ----- hw/rtl/rhc_div_cell.sv -----
// divider cell: one quotient bit of the hue and saturation divisions
module rhc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rhc_pkg::stage_t stage_i,
  output rhc_pkg::stage_t stage_o
);
  import rhc_pkg::*;

  logic  valid_q;
  side_t side_q;
  lane_t hue_d, hue_q, sat_d, sat_q;

  assign hue_d = div_step(stage_i.hue);
  assign sat_d = div_step(stage_i.sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= stage_i.side;
    hue_q  <= hue_d;
    sat_q  <= sat_d;
  end

  assign stage_o = '{valid: valid_q, side: side_q, hue: hue_q, sat: sat_q};

endmodule

// ----- hw/rtl/rhc_back.sv -----
// back stage: hue offset and wrap, gray override, output register
module rhc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rhc_pkg::stage_t stage_i,
  output logic            valid_o,
  output rhc_pkg::hsv_t   res_o
);
  import rhc_pkg::*;

  logic [HueW+1:0] sum;
  logic [HueW+1:0] wrapped;
  logic            valid_q;
  hsv_t            res_d, res_q;

  always_comb begin
    if (stage_i.side.neg) begin
      sum = {2'b00, stage_i.side.offset} - {1'b0, stage_i.hue.quo};
    end else begin
      sum = {2'b00, stage_i.side.offset} + {1'b0, stage_i.hue.quo};
    end
    // only the red sector can go below zero
    wrapped = sum[HueW+1] ? (sum + {2'b00, HueFull}) : sum;

    res_d.hue        = stage_i.side.gray ? '0 : wrapped[HueW-1:0];
    res_d.saturation = stage_i.side.gray ? '0 : stage_i.sat.quo;
    res_d.value      = stage_i.side.value;
    res_d.alpha_out  = stage_i.side.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// rgb to hsv converter top level: front stage, divider cell chain, back stage
//
//   port      dir  meaning
//   start     in   pixel transfer request, taken when busy is low
//   busy      out  always low, a pixel is taken every cycle
//   pix_i     in   red, green, blue, alpha_in
//   valid_o   out  one-cycle strobe marking a result
//   res_o     out  hue, saturation, value, alpha_out
//
// one pixel per cycle, each result follows its transfer through the pipeline below
// pipeline: front stage, 17 divider cells (one quotient bit each), back stage
// reset clears the valid bits along the chain, data registers are not reset
// the receiver takes every result in its strobe cycle, nothing stalls
module rgb_to_hsv_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rhc_pkg::pix_t pix_i,
  output logic          valid_o,
  output rhc_pkg::hsv_t res_o
);
  import rhc_pkg::*;

  stage_t chain [QuoW+1];

  assign busy = 1'b0;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .pix_i   (pix_i),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  rhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (chain[QuoW]),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

// ----- test/rgb_to_hsv_converter_tb.sv -----
// testbench for the rgb to hsv converter: directed color table, then random pixels
module rgb_to_hsv_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int SixtyDeg   = 7680;
  localparam int FullCircle = 46080;
  localparam int SatOne     = 65536;
  localparam int Limit      = 200000;
  localparam int DrainWait  = 40;
  localparam int NumRows    = 20;

  typedef struct packed {
    pix_t pix;
    logic typed;
    hsv_t hsv;
  } row_t;

  // typed rows carry their result, the others go through the predictor
  localparam row_t ColorRows [NumRows] = '{
    '{'{8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{16'd0,     17'd0,     8'd0,   8'h00}},
    '{'{8'd255, 8'd255, 8'd255, 8'hff}, 1'b1, '{16'd0,     17'd0,     8'd255, 8'hff}},
    '{'{8'd128, 8'd128, 8'd128, 8'h5a}, 1'b1, '{16'd0,     17'd0,     8'd128, 8'h5a}},
    '{'{8'd255, 8'd0,   8'd0,   8'hff}, 1'b1, '{16'd0,     17'd65536, 8'd255, 8'hff}},
    '{'{8'd0,   8'd255, 8'd0,   8'h00}, 1'b1, '{16'd15360, 17'd65536, 8'd255, 8'h00}},
    '{'{8'd0,   8'd0,   8'd255, 8'ha5}, 1'b1, '{16'd30720, 17'd65536, 8'd255, 8'ha5}},
    '{'{8'd255, 8'd255, 8'd0,   8'h5a}, 1'b1, '{16'd7680,  17'd65536, 8'd255, 8'h5a}},
    '{'{8'd0,   8'd255, 8'd255, 8'h01}, 1'b1, '{16'd23040, 17'd65536, 8'd255, 8'h01}},
    '{'{8'd255, 8'd0,   8'd255, 8'h80}, 1'b1, '{16'd38400, 17'd65536, 8'd255, 8'h80}},
    '{'{8'd1,   8'd0,   8'd0,   8'h7f}, 1'b1, '{16'd0,     17'd65536, 8'd1,   8'h7f}},
    '{'{8'd255, 8'd0,   8'd1,   8'hfe}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd255, 8'h33}, 1'b0, '0},
    '{'{8'd254, 8'd255, 8'd255, 8'hcc}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd254, 8'h0f}, 1'b0, '0},
    '{'{8'd0,   8'd100, 8'd200, 8'h55}, 1'b0, '0},
    '{'{8'd10,  8'd200, 8'd30,  8'haa}, 1'b0, '0},
    '{'{8'd200, 8'd100, 8'd150, 8'h3c}, 1'b0, '0},
    '{'{8'd17,  8'd34,  8'd250, 8'hc3}, 1'b0, '0},
    '{'{8'd1,   8'd1,   8'd0,   8'h00}, 1'b0, '0},
    '{'{8'd255, 8'd128, 8'd0,   8'hff}, 1'b0, '0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  pix_t pix_i  = '0;
  logic valid_o;
  hsv_t res_o;

  hsv_t next_hsv = '0;
  hsv_t hsv_pending [$];
  int   fail_cnt  = 0;
  int   cycle_cnt = 0;
  int   idle_pct  = 0;

  rgb_to_hsv_converter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pix_i   (pix_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic hsv_t hsv_of(pix_t p);
    int   mx, mn, span, base, up, dn, q, h;
    hsv_t r;
    mx = p.red;
    if (p.green > mx) mx = p.green;
    if (p.blue > mx) mx = p.blue;
    mn = p.red;
    if (p.green < mn) mn = p.green;
    if (p.blue < mn) mn = p.blue;
    span = mx - mn;
    r.hue        = '0;
    r.saturation = '0;
    r.value      = 8'(mx);
    r.alpha_out  = p.alpha_in;
    if (span > 0) begin
      // sector of the first channel at max, red before green before blue
      if (mx == p.red) begin
        base = 0;
        up   = p.green;
        dn   = p.blue;
      end else if (mx == p.green) begin
        base = 2 * SixtyDeg;
        up   = p.blue;
        dn   = p.red;
      end else begin
        base = 4 * SixtyDeg;
        up   = p.red;
        dn   = p.green;
      end
      q = (up >= dn) ? (SixtyDeg * (up - dn)) / span : (SixtyDeg * (dn - up)) / span;
      h = (up >= dn) ? base + q : base - q;
      if (h < 0) h += FullCircle;
      if (h >= FullCircle) h -= FullCircle;
      r.hue        = 16'(h);
      r.saturation = 17'((span * SatOne) / mx);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(3, 1));
      3:       return 8'($urandom_range(254, 252));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // random idle cycles, then hold start until the transfer
  task automatic send_pixel(pix_t p, hsv_t e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      pix_i <= pix_t'($urandom);
      @(posedge clk_i);
    end
    start    <= 1'b1;
    pix_i    <= p;
    next_hsv <= e;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (hsv_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int pct, int n);
    pix_t p;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      p.red      = pick_chan();
      p.green    = pick_chan();
      p.blue     = pick_chan();
      p.alpha_in = 8'($urandom);
      // grays and channel ties exercise the sector priority
      case ($urandom_range(7))
        0: begin
          p.green = p.red;
          p.blue  = p.red;
        end
        1: p.green = p.red;
        2: p.blue  = p.green;
        3: p.red   = p.blue;
        default: ;
      endcase
      send_pixel(p, hsv_of(p));
    end
    settle();
  endtask

  // check results and record every accepted pixel
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if (valid_o !== 1'b0) begin
        if (hsv_pending.size() == 0) begin
          $error("result with no pixel waiting: %p", res_o);
          fail_cnt++;
        end else begin
          want = hsv_pending.pop_front();
          if (res_o.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, res_o.hue);
            fail_cnt++;
          end
          if (res_o.saturation !== want.saturation) begin
            $error("saturation: expected %0d, got %0d", want.saturation, res_o.saturation);
            fail_cnt++;
          end
          if (res_o.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, res_o.value);
            fail_cnt++;
          end
          if (res_o.alpha_out !== want.alpha_out) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha_out, res_o.alpha_out);
            fail_cnt++;
          end
        end
      end
      if (start && busy === 1'b0) hsv_pending.push_back(next_hsv);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == Limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 0;
    for (int i = 0; i < NumRows; i++) begin
      send_pixel(ColorRows[i].pix,
                 ColorRows[i].typed ? ColorRows[i].hsv : hsv_of(ColorRows[i].pix));
    end
    settle();
    run_phase(17, 600);
    run_phase(47, 600);
    run_phase(0, 650);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0 && hsv_pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_front.sv
hw/rtl/rhc_div_cell.sv
hw/rtl/rhc_back.sv
hw/rtl/rgb_to_hsv_converter.sv
test/rgb_to_hsv_converter_tb.sv
